### design/u8250_pkg.sv
package u8250_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_HOST  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOST_ATTACHED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TXE_DELAY     = 8'd1;

  localparam logic [2:0] OFS_DATA = 3'd0;
  localparam logic [2:0] OFS_IER  = 3'd1;
  localparam logic [2:0] OFS_IIR  = 3'd2;
  localparam logic [2:0] OFS_LCR  = 3'd3;
  localparam logic [2:0] OFS_MCR  = 3'd4;
  localparam logic [2:0] OFS_LSR  = 3'd5;
  localparam logic [2:0] OFS_MSR  = 3'd6;

  localparam int unsigned DLAB_POS = 7;
  localparam int unsigned LOOP_POS = 4;
  localparam int unsigned IE_RX_POS  = 0;
  localparam int unsigned IE_TXE_POS = 1;

  localparam logic [7:0] ID_NONE = 8'h01;
  localparam logic [7:0] ID_RX   = 8'h04;
  localparam logic [7:0] ID_TXE  = 8'h02;
  localparam logic [7:0] LS_DR   = 8'h01;
  localparam logic [7:0] LS_TXE  = 8'h20;

  localparam logic [7:0]  MS_RESET    = 8'hB0;
  localparam logic [15:0] DELAY_RESET = 16'd5000;

endpackage

### design/u8250_if.sv
interface u8250_req_if;
  import u8250_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] host_byte;

  modport source (output valid, opcode, reg_offset, write_data, host_byte, input ready);
  modport sink   (input valid, opcode, reg_offset, write_data, host_byte, output ready);
endinterface

interface u8250_rsp_if;
  import u8250_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       irq;
  logic       rx_dropped;

  modport source (output valid, read_data, tx_valid, tx_byte, irq, rx_dropped, input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, irq, rx_dropped, output ready);
endinterface

interface u8250_cfg_if;
  import u8250_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/uart_8250_register_model.sv
// Results are registered at acceptance and shown on the response channel next cycle.
// Throughput: one request per cycle; a request is taken while the previous result
// is being consumed, the single output register stalls only when the sink holds off.
// FIFO bytes come out of a one-port-read synchronous memory read at acceptance.
// Reset: registers to their 8250 reset values, FIFO empty; stored bytes undefined.
module uart_8250_register_model #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  u8250_cfg_if.sink          cfg_i,
  u8250_req_if.sink          req_i,
  u8250_rsp_if.source        rsp_o
);
  import u8250_pkg::*;

  localparam int unsigned AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RX_DEPTH + 1);
  localparam int unsigned SW = FW + 1;

  // configuration
  logic        host_q;
  logic [15:0] delay_q;

  // register file state
  logic [7:0]  lcr_q, lcr_d;
  logic [7:0]  mcr_q, mcr_d;
  logic [7:0]  msr_q, msr_d;
  logic [7:0]  dll_q, dll_d;
  logic [7:0]  dlm_q, dlm_d;
  logic [7:0]  ier_q, ier_d;
  logic [7:0]  iir_q, iir_d;
  logic        echo_full_q, echo_full_d;
  logic [7:0]  echo_char_q, echo_char_d;
  logic        busy_q, busy_d;
  logic [15:0] count_q, count_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] head_q, head_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_rd_q, out_rd_d;
  logic       out_mem_q, out_mem_d;
  logic       out_txv_q, out_txv_d;
  logic [7:0] out_txb_q, out_txb_d;
  logic       out_irq_q;
  logic       out_drop_q, out_drop_d;

  // receive store
  logic [7:0]    rx_mem_q [RX_DEPTH];
  logic [7:0]    rx_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] wsum;

  logic accept;
  logic check;
  logic dlab, loop;
  logic lsr_avail;
  op_e  op;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign op          = op_e'(req_i.opcode);
  assign dlab        = lcr_q[DLAB_POS];
  assign loop        = mcr_q[LOOP_POS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_q  <= 1'b0;
      delay_q <= DELAY_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_HOST_ATTACHED) begin
        host_q <= cfg_i.data[0];
      end else if (cfg_i.index == CFG_TXE_DELAY) begin
        delay_q <= cfg_i.data;
      end
    end
  end

  always_comb begin
    wsum = SW'(head_q) + SW'(fill_q);
    if (wsum >= SW'(RX_DEPTH)) begin
      wsum = wsum - SW'(RX_DEPTH);
    end
    mem_waddr = wsum[AW-1:0];
  end

  always_comb begin
    lcr_d       = lcr_q;
    mcr_d       = mcr_q;
    msr_d       = msr_q;
    dll_d       = dll_q;
    dlm_d       = dlm_q;
    ier_d       = ier_q;
    echo_full_d = echo_full_q;
    echo_char_d = echo_char_q;
    busy_d      = busy_q;
    count_d     = count_q;
    fill_d      = fill_q;
    head_d      = head_q;
    check       = 1'b0;
    mem_we      = 1'b0;
    out_rd_d    = '0;
    out_mem_d   = 1'b0;
    out_txv_d   = 1'b0;
    out_txb_d   = '0;
    out_drop_d  = 1'b0;
    lsr_avail   = loop ? echo_full_q : (host_q && (fill_q != '0));

    unique case (op)
      OP_READ: begin
        unique case (req_i.reg_offset)
          OFS_DATA: begin
            if (dlab) begin
              out_rd_d = dll_q;
            end else begin
              if (loop) begin
                echo_full_d = 1'b0;
                out_rd_d    = echo_char_q;
              end else if (host_q && (fill_q != '0)) begin
                // pop: byte arrives from the memory next cycle
                out_mem_d = 1'b1;
                fill_d    = fill_q - FW'(1);
                head_d    = (head_q == AW'(RX_DEPTH - 1)) ? '0 : head_q + AW'(1);
              end
              check = 1'b1;
            end
          end
          OFS_IER: out_rd_d = dlab ? dlm_q : ier_q;
          OFS_IIR: out_rd_d = iir_q;
          OFS_LCR: out_rd_d = lcr_q;
          OFS_MCR: out_rd_d = mcr_q;
          OFS_LSR: out_rd_d = (busy_q ? 8'h00 : LS_TXE) | (lsr_avail ? LS_DR : 8'h00);
          OFS_MSR: out_rd_d = msr_q;
          default: out_rd_d = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (req_i.reg_offset)
          OFS_DATA: begin
            if (dlab) begin
              dll_d = req_i.write_data;
            end else begin
              if (loop) begin
                echo_char_d = req_i.write_data;
                echo_full_d = 1'b1;
              end else if (host_q) begin
                out_txv_d = 1'b1;
                out_txb_d = req_i.write_data;
              end
              if (host_q) begin
                busy_d  = 1'b1;
                count_d = (delay_q == '0) ? 16'd1 : delay_q;
                check   = 1'b1;
              end
            end
          end
          OFS_IER: begin
            if (dlab) begin
              dlm_d = req_i.write_data;
            end else begin
              ier_d = req_i.write_data;
              check = 1'b1;
            end
          end
          OFS_LCR: lcr_d = req_i.write_data;
          OFS_MCR: begin
            if (req_i.write_data[LOOP_POS] && !loop) begin
              echo_full_d = 1'b0;
            end
            mcr_d = req_i.write_data;
          end
          OFS_MSR: msr_d = req_i.write_data;
          default: ;
        endcase
      end
      OP_HOST: begin
        if (host_q) begin
          if (fill_q >= FW'(RX_DEPTH)) begin
            out_drop_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            fill_d = fill_q + FW'(1);
          end
          check = 1'b1;
        end
      end
      OP_TICK: begin
        if (busy_q) begin
          if (count_q != '0) begin
            count_d = count_q - 16'd1;
          end
          if (count_d == '0) begin
            busy_d = 1'b0;
            check  = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // priority-encode identification from the updated state
    iir_d = iir_q;
    if (check && host_q) begin
      if (ier_d[IE_RX_POS] && (fill_d != '0)) begin
        iir_d = ID_RX;
      end else if (ier_d[IE_TXE_POS] && !busy_d) begin
        iir_d = ID_TXE;
      end else begin
        iir_d = ID_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q       <= '0;
      mcr_q       <= '0;
      msr_q       <= MS_RESET;
      dll_q       <= '0;
      dlm_q       <= '0;
      ier_q       <= '0;
      iir_q       <= ID_NONE;
      echo_full_q <= 1'b0;
      echo_char_q <= '0;
      busy_q      <= 1'b0;
      count_q     <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      out_irq_q   <= 1'b0;
    end else begin
      if (accept) begin
        lcr_q       <= lcr_d;
        mcr_q       <= mcr_d;
        msr_q       <= msr_d;
        dll_q       <= dll_d;
        dlm_q       <= dlm_d;
        ier_q       <= ier_d;
        iir_q       <= iir_d;
        echo_full_q <= echo_full_d;
        echo_char_q <= echo_char_d;
        busy_q      <= busy_d;
        count_q     <= count_d;
        fill_q      <= fill_d;
        head_q      <= head_d;
        out_irq_q   <= (iir_d != ID_NONE);
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rd_q   <= out_rd_d;
      out_mem_q  <= out_mem_d;
      out_txv_q  <= out_txv_d;
      out_txb_q  <= out_txb_d;
      out_drop_q <= out_drop_d;
    end
  end

  // receive store: write a host byte at the tail, read the head on every request
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      rx_mem_q[mem_waddr] <= req_i.host_byte;
    end
    if (accept) begin
      rx_rdata_q <= rx_mem_q[head_q];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_data  = out_mem_q ? rx_rdata_q : out_rd_q;
  assign rsp_o.tx_valid   = out_txv_q;
  assign rsp_o.tx_byte    = out_txb_q;
  assign rsp_o.irq        = out_irq_q;
  assign rsp_o.rx_dropped = out_drop_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RX_DEPTH))
    else $error("receive fill beyond depth");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (count_q != '0))
    else $error("transmit busy with expired countdown");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_HOST) && host_q && (fill_q < FW'(RX_DEPTH)))
    |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("host byte not queued");

  a_irq_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_TICK)) |=> (rsp_o.irq == (iir_q != ID_NONE)))
    else $error("interrupt line disagrees with identification");

endmodule
